// ===== hw/rtl/scpp_pkg.sv =====
package scpp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned IDX_W       = 4;
  // only the first twelve payload bytes feed the result
  localparam int unsigned STORE_DEPTH = 12;
  localparam int unsigned NUM_POS     = 5;

  localparam logic [BYTE_W-1:0] CH_HEAD  = 8'h46;
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h52;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h4C;

  localparam logic [WORD_W-1:0] MIRROR_CENTER = 16'd180;

endpackage

// ===== hw/rtl/scpp_mirror.sv =====
module scpp_mirror (
  input  logic                          side_left_i,
  input  logic [scpp_pkg::WORD_W-1:0]   value_i,
  output logic [scpp_pkg::WORD_W-1:0]   value_o
);
  import scpp_pkg::*;

  logic [WORD_W-1:0] above;
  logic [WORD_W-1:0] below;

  assign above = value_i - MIRROR_CENTER;
  assign below = MIRROR_CENTER - value_i;

  // right side passes the value through; left side: distance from the center position
  always_comb begin
    if (!side_left_i) begin
      value_o = value_i;
    end else if (value_i >= MIRROR_CENTER) begin
      value_o = above;
    end else begin
      value_o = below;
    end
  end

endmodule

// ===== hw/rtl/servo_command_packet_parser_unit.sv =====
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+------------------------------------------
// rx input  | in_valid_i   | in_stall_o   | rx_byte_i
// result    | out_valid_o  | out_stall_i  | pos_one_o .. pos_five_o, move_speed_o
// config    | cfg_wr_en_i  | (none)       | cfg_wr_data_i (side_left)
//
// one byte is taken every cycle unless the input stalls; a packet result appears in the output register
// the cycle after its last payload byte is taken.
// rst_ni (async, active low) returns the parser to waiting for the header and
// empties the output register; the payload store holds no reset value.
// the input stalls only while a result sits in the output register and the
// result side stalls; a result taken in the same cycle frees the slot at once.
module servo_command_packet_parser_unit #(
  parameter int unsigned PAYLOAD_BYTES = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_wr_en_i,
  input  logic                          cfg_wr_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [scpp_pkg::BYTE_W-1:0]   rx_byte_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [scpp_pkg::WORD_W-1:0]   pos_one_o,
  output logic [scpp_pkg::WORD_W-1:0]   pos_two_o,
  output logic [scpp_pkg::WORD_W-1:0]   pos_three_o,
  output logic [scpp_pkg::WORD_W-1:0]   pos_four_o,
  output logic [scpp_pkg::WORD_W-1:0]   pos_five_o,
  output logic [scpp_pkg::WORD_W-1:0]   move_speed_o
);
  import scpp_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_HEAD,
    PH_WAIT_SIDE,
    PH_COLLECT
  } phase_e;

  localparam logic [IDX_W-1:0] LastCount = IDX_W'(PAYLOAD_BYTES);

  phase_e             phase_q, phase_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   idx_inc;
  logic               side_left_q;
  logic               out_valid_q, out_valid_d;
  logic               in_acc;
  logic               emit;
  logic               store_we;

  logic [BYTE_W-1:0]  store_q [STORE_DEPTH];
  logic [BYTE_W-1:0]  view    [STORE_DEPTH];
  logic [WORD_W-1:0]  raw_pos [NUM_POS];
  logic [WORD_W-1:0]  mir_pos [NUM_POS];
  logic [WORD_W-1:0]  pos_q   [NUM_POS];
  logic [WORD_W-1:0]  speed_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign idx_inc    = idx_q + 1'b1;
  assign store_we   = in_acc && (phase_q == PH_COLLECT) && (idx_q < IDX_W'(STORE_DEPTH));

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    emit    = 1'b0;
    if (in_acc) begin
      priority if (rx_byte_i == CH_HEAD) begin
        // a header byte restarts the packet anywhere
        phase_d = PH_WAIT_SIDE;
        idx_d   = '0;
      end else if (phase_q == PH_WAIT_SIDE &&
                   (rx_byte_i == CH_RIGHT || rx_byte_i == CH_LEFT)) begin
        phase_d = ((rx_byte_i == CH_LEFT) == side_left_q) ? PH_COLLECT : PH_WAIT_HEAD;
        idx_d   = '0;
      end else if (phase_q == PH_COLLECT) begin
        if (idx_inc >= LastCount || idx_inc == '0) begin
          emit    = 1'b1;
          phase_d = PH_WAIT_HEAD;
          idx_d   = '0;
        end else begin
          idx_d   = idx_inc;
        end
      end else begin
        phase_d = PH_WAIT_HEAD;
        idx_d   = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // the byte arriving now stands in for its store entry
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      view[i] = (phase_q == PH_COLLECT && idx_q == IDX_W'(i)) ? rx_byte_i : store_q[i];
    end
    for (int k = 0; k < NUM_POS; k++) begin
      raw_pos[k] = {view[2*k+1], view[2*k]};
    end
  end

  for (genvar k = 0; k < NUM_POS; k++) begin : g_mirror
    scpp_mirror u_mirror (
      .side_left_i (side_left_q),
      .value_i     (raw_pos[k]),
      .value_o     (mir_pos[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT_HEAD;
      idx_q       <= '0;
      side_left_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        side_left_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[idx_q] <= rx_byte_i;
    end
    if (emit) begin
      for (int k = 0; k < NUM_POS; k++) begin
        pos_q[k] <= mir_pos[k];
      end
      speed_q <= {view[11], view[10]};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_one_o    = pos_q[0];
  assign pos_two_o    = pos_q[1];
  assign pos_three_o  = pos_q[2];
  assign pos_four_o   = pos_q[3];
  assign pos_five_o   = pos_q[4];
  assign move_speed_o = speed_q;

  a_idx_only_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_COLLECT |-> idx_q == '0)
    else $error("byte index nonzero outside payload");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < LastCount)
    else $error("byte index beyond payload length");

  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> phase_q == PH_WAIT_HEAD && out_valid_q)
    else $error("parser not restarted after packet");

  a_head_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && rx_byte_i == CH_HEAD |=> phase_q == PH_WAIT_SIDE && !$rose(out_valid_q))
    else $error("header byte did not restart parser");

endmodule
